// ===== hdl/rpnp_pkg.sv =====
// shared types and constants of the ray proximity nearest pick block
package rpnp_pkg;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int QUEUE_DEPTH     = 4;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_ORIGIN_X  = 3'd0,
        CFG_ORIGIN_Y  = 3'd1,
        CFG_ORIGIN_Z  = 3'd2,
        CFG_DIR_X     = 3'd3,
        CFG_DIR_Y     = 3'd4,
        CFG_DIR_Z     = 3'd5,
        CFG_RADIUS_SQ = 3'd6,
        CFG_MIN_DIST  = 3'd7
    } t_cfg_idx;

endpackage

// ===== hdl/rpnp_if.sv =====
// channel interfaces: object input, pick result output and register writes
interface rpnp_in_if #(
    parameter int CW  = 32,
    parameter int IDW = 32
);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic signed [CW-1:0] center_z;
    logic                 object_visible;
    logic [IDW-1:0]       object_id;
    logic                 last_object;

    modport source (output valid, center_x, center_y, center_z, object_visible, object_id,
                     last_object, input ready);
    modport sink (input valid, center_x, center_y, center_z, object_visible, object_id,
                  last_object, output ready);
endinterface

interface rpnp_out_if #(
    parameter int CW  = 32,
    parameter int IDW = 32
);
    logic                 valid;
    logic                 ready;
    logic                 hit_found;
    logic [IDW-1:0]       hit_id;
    logic [CW-2:0]        hit_distance;
    logic signed [CW-1:0] hit_point_x;
    logic signed [CW-1:0] hit_point_y;
    logic signed [CW-1:0] hit_point_z;

    modport source (output valid, hit_found, hit_id, hit_distance, hit_point_x, hit_point_y,
                     hit_point_z, input ready);
    modport sink (input valid, hit_found, hit_id, hit_distance, hit_point_x, hit_point_y,
                  hit_point_z, output ready);
endinterface

interface rpnp_cfg_if #(
    parameter int CW = 32
);
    import rpnp_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [CFG_INDEX_WIDTH-1:0] index;
    logic [CW-1:0]              data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/rpnp_front.sv =====
// front pipeline: accepts objects, computes t and the distance pre-check
module rpnp_front import rpnp_pkg::*; #(
    parameter int CW  = 32,
    parameter int FB  = 16,
    parameter int IDW = 32,
    parameter int QW  = 4*CW + IDW + 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rpnp_in_if.sink              i_obj,
    input  logic signed [CW-1:0] i_origin_x,
    input  logic signed [CW-1:0] i_origin_y,
    input  logic signed [CW-1:0] i_origin_z,
    input  logic signed [CW-1:0] i_dir_x,
    input  logic signed [CW-1:0] i_dir_y,
    input  logic signed [CW-1:0] i_dir_z,
    input  logic [CW-2:0]        i_min_dist,
    output logic                 o_q_valid,
    input  logic                 i_q_ready,
    output logic [QW-1:0]        o_q_data
);
    localparam int DW   = CW + 1;
    localparam int PW   = 2*CW + 1;
    localparam int DOTW = 2*CW + 3;
    localparam logic signed [DOTW-1:0] T_MAX = {{(DOTW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [DOTW-1:0] T_MIN = ~T_MAX;

    logic                 w_en;
    logic                 r_v1, r_v2;
    logic signed [DW-1:0] r1_dx, r1_dy, r1_dz;
    logic signed [CW-1:0] r1_cx, r1_cy, r1_cz, r2_cx, r2_cy, r2_cz;
    logic [IDW-1:0]       r1_id, r2_id;
    logic                 r1_vis, r2_vis, r1_last, r2_last;
    logic signed [PW-1:0] r2_px, r2_py, r2_pz;
    logic signed [DOTW-1:0] w_dot, w_sh;
    logic signed [CW-1:0] w_t;
    logic                 w_cand;

    assign w_en        = !r_v2 || i_q_ready;
    assign i_obj.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_obj.valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_dx   <= DW'(i_obj.center_x) - DW'(i_origin_x);
            r1_dy   <= DW'(i_obj.center_y) - DW'(i_origin_y);
            r1_dz   <= DW'(i_obj.center_z) - DW'(i_origin_z);
            r1_cx   <= i_obj.center_x;
            r1_cy   <= i_obj.center_y;
            r1_cz   <= i_obj.center_z;
            r1_id   <= i_obj.object_id;
            r1_vis  <= i_obj.object_visible;
            r1_last <= i_obj.last_object;
            r2_px   <= PW'(r1_dx) * PW'(i_dir_x);
            r2_py   <= PW'(r1_dy) * PW'(i_dir_y);
            r2_pz   <= PW'(r1_dz) * PW'(i_dir_z);
            r2_cx   <= r1_cx;
            r2_cy   <= r1_cy;
            r2_cz   <= r1_cz;
            r2_id   <= r1_id;
            r2_vis  <= r1_vis;
            r2_last <= r1_last;
        end
    end

    // floor by the fraction bits, then saturate
    always_comb begin
        w_dot = DOTW'(r2_px) + DOTW'(r2_py) + DOTW'(r2_pz);
        w_sh  = w_dot >>> FB;
        if (w_sh > T_MAX) begin
            w_t = T_MAX[CW-1:0];
        end else if (w_sh < T_MIN) begin
            w_t = T_MIN[CW-1:0];
        end else begin
            w_t = w_sh[CW-1:0];
        end
        w_cand = r2_vis && (w_t >= $signed({1'b0, i_min_dist}));
    end

    assign o_q_valid = r_v2;
    assign o_q_data  = {r2_cx, r2_cy, r2_cz, r2_id, r2_last, w_cand, w_t};

endmodule

// ===== hdl/rpnp_queue.sv =====
// small fifo between the front and back pipelines
module rpnp_queue import rpnp_pkg::*; #(
    parameter int W     = 32,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr_valid,
    output logic         o_wr_ready,
    input  logic [W-1:0] i_wr_data,
    output logic         o_rd_valid,
    input  logic         i_rd_ready,
    output logic [W-1:0] o_rd_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [W-1:0]    r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNTW-1:0] r_count;
    logic            w_push, w_pop;

    assign o_wr_ready = (r_count != CNTW'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = o_rd_valid && i_rd_ready;
    assign o_rd_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

// ===== hdl/rpnp_back.sv =====
// back pipeline: closest ray point, radius test, nearest tracking and result register
module rpnp_back import rpnp_pkg::*; #(
    parameter int CW  = 32,
    parameter int FB  = 16,
    parameter int IDW = 32,
    parameter int QW  = 4*CW + IDW + 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    output logic                 o_q_ready,
    input  logic [QW-1:0]        i_q_data,
    input  logic signed [CW-1:0] i_origin_x,
    input  logic signed [CW-1:0] i_origin_y,
    input  logic signed [CW-1:0] i_origin_z,
    input  logic signed [CW-1:0] i_dir_x,
    input  logic signed [CW-1:0] i_dir_y,
    input  logic signed [CW-1:0] i_dir_z,
    input  logic [CW-1:0]        i_radius_sq,
    rpnp_out_if.source           o_hit
);
    localparam int MW  = 2*CW;
    localparam int SW  = 2*CW - FB + 1;
    localparam int DW  = CW + 1;
    localparam int QSW = 2*CW + 2;
    localparam int SQW = 2*CW + 4;
    localparam logic signed [SW-1:0] P_MAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [SW-1:0] P_MIN = ~P_MAX;

    logic signed [CW-1:0] w_cx, w_cy, w_cz, w_t;
    logic [IDW-1:0]       w_id;
    logic                 w_last, w_cand, w_en;

    logic                 r1_v, r2_v, r3_v, r4_v;
    logic signed [CW-1:0] r1_cx, r1_cy, r1_cz, r2_cx, r2_cy, r2_cz;
    logic signed [CW-1:0] r1_t, r2_t, r3_t, r4_t;
    logic [IDW-1:0]       r1_id, r2_id, r3_id, r4_id;
    logic                 r1_last, r2_last, r3_last, r4_last;
    logic                 r1_cand, r2_cand, r3_cand, r4_cand;
    logic signed [MW-1:0] r1_mx, r1_my, r1_mz;
    logic signed [CW-1:0] r2_px, r2_py, r2_pz, r3_px, r3_py, r3_pz, r4_px, r4_py, r4_pz;
    logic signed [DW-1:0] r3_dx, r3_dy, r3_dz;
    logic signed [QSW-1:0] r4_qx, r4_qy, r4_qz;
    logic signed [SW-1:0] w_sx, w_sy, w_sz;
    logic signed [CW-1:0] w_px, w_py, w_pz;

    logic signed [SQW-1:0] w_dsq, w_lim;
    logic                  w_take, w_fire;
    logic                  r_found;
    logic signed [CW-1:0]  r_best_t, r_best_x, r_best_y, r_best_z;
    logic [IDW-1:0]        r_best_id;
    logic                  n_found;
    logic signed [CW-1:0]  n_best_t, n_best_x, n_best_y, n_best_z;
    logic [IDW-1:0]        n_best_id;

    logic                  r_out_v, r_out_found;
    logic [IDW-1:0]        r_out_id;
    logic [CW-2:0]         r_out_dist;
    logic signed [CW-1:0]  r_out_x, r_out_y, r_out_z;

    assign {w_cx, w_cy, w_cz, w_id, w_last, w_cand, w_t} = i_q_data;

    // only a last transaction can be held up by a full result register
    assign w_en      = !(r4_v && r4_last) || !r_out_v || o_hit.ready;
    assign o_q_ready = w_en;
    assign w_fire    = r4_v && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_q_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_comb begin
        w_sx = SW'(i_origin_x) + SW'(r1_mx >>> FB);
        w_sy = SW'(i_origin_y) + SW'(r1_my >>> FB);
        w_sz = SW'(i_origin_z) + SW'(r1_mz >>> FB);
        w_px = (w_sx > P_MAX) ? P_MAX[CW-1:0] : (w_sx < P_MIN) ? P_MIN[CW-1:0] : w_sx[CW-1:0];
        w_py = (w_sy > P_MAX) ? P_MAX[CW-1:0] : (w_sy < P_MIN) ? P_MIN[CW-1:0] : w_sy[CW-1:0];
        w_pz = (w_sz > P_MAX) ? P_MAX[CW-1:0] : (w_sz < P_MIN) ? P_MIN[CW-1:0] : w_sz[CW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_mx   <= MW'(i_dir_x) * MW'(w_t);
            r1_my   <= MW'(i_dir_y) * MW'(w_t);
            r1_mz   <= MW'(i_dir_z) * MW'(w_t);
            r1_cx   <= w_cx;
            r1_cy   <= w_cy;
            r1_cz   <= w_cz;
            r1_t    <= w_t;
            r1_id   <= w_id;
            r1_last <= w_last;
            r1_cand <= w_cand;

            r2_px   <= w_px;
            r2_py   <= w_py;
            r2_pz   <= w_pz;
            r2_cx   <= r1_cx;
            r2_cy   <= r1_cy;
            r2_cz   <= r1_cz;
            r2_t    <= r1_t;
            r2_id   <= r1_id;
            r2_last <= r1_last;
            r2_cand <= r1_cand;

            r3_dx   <= DW'(r2_cx) - DW'(r2_px);
            r3_dy   <= DW'(r2_cy) - DW'(r2_py);
            r3_dz   <= DW'(r2_cz) - DW'(r2_pz);
            r3_px   <= r2_px;
            r3_py   <= r2_py;
            r3_pz   <= r2_pz;
            r3_t    <= r2_t;
            r3_id   <= r2_id;
            r3_last <= r2_last;
            r3_cand <= r2_cand;

            r4_qx   <= QSW'(r3_dx) * QSW'(r3_dx);
            r4_qy   <= QSW'(r3_dy) * QSW'(r3_dy);
            r4_qz   <= QSW'(r3_dz) * QSW'(r3_dz);
            r4_px   <= r3_px;
            r4_py   <= r3_py;
            r4_pz   <= r3_pz;
            r4_t    <= r3_t;
            r4_id   <= r3_id;
            r4_last <= r3_last;
            r4_cand <= r3_cand;
        end
    end

    // radius test and nearest compare, first one wins on ties
    always_comb begin
        w_dsq  = SQW'(r4_qx) + SQW'(r4_qy) + SQW'(r4_qz);
        w_lim  = $signed(SQW'({i_radius_sq, {FB{1'b0}}}));
        w_take = r4_v && r4_cand && (w_dsq <= w_lim) && (!r_found || (r4_t < r_best_t));
        n_found   = r_found || w_take;
        n_best_t  = w_take ? r4_t  : r_best_t;
        n_best_id = w_take ? r4_id : r_best_id;
        n_best_x  = w_take ? r4_px : r_best_x;
        n_best_y  = w_take ? r4_py : r_best_y;
        n_best_z  = w_take ? r4_pz : r_best_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found   <= 1'b0;
            r_best_t  <= '0;
            r_best_id <= '0;
            r_best_x  <= '0;
            r_best_y  <= '0;
            r_best_z  <= '0;
            r_out_v   <= 1'b0;
        end else begin
            if (w_fire && r4_last) begin
                r_found   <= 1'b0;
                r_best_t  <= '0;
                r_best_id <= '0;
                r_best_x  <= '0;
                r_best_y  <= '0;
                r_best_z  <= '0;
            end else if (w_fire) begin
                r_found   <= n_found;
                r_best_t  <= n_best_t;
                r_best_id <= n_best_id;
                r_best_x  <= n_best_x;
                r_best_y  <= n_best_y;
                r_best_z  <= n_best_z;
            end
            if (w_fire && r4_last) begin
                r_out_v <= 1'b1;
            end else if (o_hit.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r4_last) begin
            r_out_found <= n_found;
            r_out_id    <= n_best_id;
            r_out_dist  <= n_best_t[CW-2:0];
            r_out_x     <= n_best_x;
            r_out_y     <= n_best_y;
            r_out_z     <= n_best_z;
        end
    end

    assign o_hit.valid        = r_out_v;
    assign o_hit.hit_found    = r_out_found;
    assign o_hit.hit_id       = r_out_id;
    assign o_hit.hit_distance = r_out_dist;
    assign o_hit.hit_point_x  = r_out_x;
    assign o_hit.hit_point_y  = r_out_y;
    assign o_hit.hit_point_z  = r_out_z;

endmodule

// ===== hdl/ray_proximity_nearest_pick_core.sv =====
// top level of the ray proximity nearest pick block
// Picks the object nearest along a ray. Ray origin, direction, squared pick radius and
// minimum distance are registers written over the configuration channel; write them
// while no pick is in flight. Each input transaction carries one object center; on the
// transaction marked last one result transaction is produced with the nearest accepted
// object, or all zeros on a miss, and the tracking state is cleared. Both the front
// pipeline (dot product and t) and the back pipeline (closest point, radius test,
// nearest compare) take one transaction per clock unless a full queue or a full result
// register stalls them, so the sustained rate is one object per cycle; the only loop is
// the compare against the kept best t. A result follows its last object through the two
// front stages, the queue, the four back stages and the result register.
module ray_proximity_nearest_pick_core import rpnp_pkg::*; #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    parameter int ID_WIDTH    = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rpnp_cfg_if.sink   i_cfg,
    rpnp_in_if.sink    i_obj,
    rpnp_out_if.source o_hit
);
    localparam int CW = COORD_WIDTH;
    localparam int QW = 4*CW + ID_WIDTH + 2;
    localparam logic [CW-1:0]   DIR_Z_RESET  = CW'(64'd1 << FRAC_BITS);
    localparam logic [CW-1:0]   RADIUS_RESET = CW'((64'd9 << FRAC_BITS) / 4);
    localparam logic [CW-2:0]   MIN_RESET    = (CW-1)'((64'd1 << FRAC_BITS) / 100);

    logic signed [CW-1:0] r_origin_x, r_origin_y, r_origin_z;
    logic signed [CW-1:0] r_dir_x, r_dir_y, r_dir_z;
    logic [CW-1:0]        r_radius_sq;
    logic [CW-2:0]        r_min_dist;

    logic                 w_fq_valid, w_fq_ready, w_bq_valid, w_bq_ready;
    logic [QW-1:0]        w_fq_data, w_bq_data;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x  <= '0;
            r_origin_y  <= '0;
            r_origin_z  <= '0;
            r_dir_x     <= '0;
            r_dir_y     <= '0;
            r_dir_z     <= DIR_Z_RESET;
            r_radius_sq <= RADIUS_RESET;
            r_min_dist  <= MIN_RESET;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_ORIGIN_X:  r_origin_x  <= i_cfg.data;
                CFG_ORIGIN_Y:  r_origin_y  <= i_cfg.data;
                CFG_ORIGIN_Z:  r_origin_z  <= i_cfg.data;
                CFG_DIR_X:     r_dir_x     <= i_cfg.data;
                CFG_DIR_Y:     r_dir_y     <= i_cfg.data;
                CFG_DIR_Z:     r_dir_z     <= i_cfg.data;
                CFG_RADIUS_SQ: r_radius_sq <= i_cfg.data;
                CFG_MIN_DIST:  r_min_dist  <= i_cfg.data[CW-2:0];
                default: begin
                end
            endcase
        end
    end

    rpnp_front #(
        .CW  (CW),
        .FB  (FRAC_BITS),
        .IDW (ID_WIDTH),
        .QW  (QW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_obj      (i_obj),
        .i_origin_x (r_origin_x),
        .i_origin_y (r_origin_y),
        .i_origin_z (r_origin_z),
        .i_dir_x    (r_dir_x),
        .i_dir_y    (r_dir_y),
        .i_dir_z    (r_dir_z),
        .i_min_dist (r_min_dist),
        .o_q_valid  (w_fq_valid),
        .i_q_ready  (w_fq_ready),
        .o_q_data   (w_fq_data)
    );

    rpnp_queue #(
        .W     (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_fq_valid),
        .o_wr_ready (w_fq_ready),
        .i_wr_data  (w_fq_data),
        .o_rd_valid (w_bq_valid),
        .i_rd_ready (w_bq_ready),
        .o_rd_data  (w_bq_data)
    );

    rpnp_back #(
        .CW  (CW),
        .FB  (FRAC_BITS),
        .IDW (ID_WIDTH),
        .QW  (QW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_bq_valid),
        .o_q_ready   (w_bq_ready),
        .i_q_data    (w_bq_data),
        .i_origin_x  (r_origin_x),
        .i_origin_y  (r_origin_y),
        .i_origin_z  (r_origin_z),
        .i_dir_x     (r_dir_x),
        .i_dir_y     (r_dir_y),
        .i_dir_z     (r_dir_z),
        .i_radius_sq (r_radius_sq),
        .o_hit       (o_hit)
    );

endmodule
